// ----- design/lsc_pkg.sv -----
// Package for the launch sequence controller.
// Types, codes and fixed-point constants shared by lsc_front, lsc_back and the top level.
package lsc_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ACCEL_ONE   = 3'd0,
      CSR_ACCEL_TWO   = 3'd1,
      CSR_ACCEL_THREE = 3'd2,
      CSR_TIME_ONE    = 3'd3,
      CSR_TIME_TWO    = 3'd4,
      CSR_TIME_THREE  = 3'd5,
      CSR_RPM_ONE     = 3'd6,
      CSR_RPM_TWO     = 3'd7
   } csr_index_type;

   typedef logic [1:0] phase_type;
   localparam phase_type PHASE_IDLE  = 2'd0;
   localparam phase_type PHASE_ONE   = 2'd1;
   localparam phase_type PHASE_TWO   = 2'd2;
   localparam phase_type PHASE_THREE = 2'd3;

   typedef enum logic [1:0] {
      CMD_HOLD = 2'd0,
      CMD_STOP = 2'd1,
      CMD_GO   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_MUL  = 2'd1,
      ST_DIV  = 2'd2,
      ST_SUM  = 2'd3
   } state_type;

   // throttle thresholds in Q8.8: 0.1 -> 26 (strict below), 0.5 -> 128 (strict above)
   localparam logic signed [15:0] THR_STOP = 16'sd26;
   localparam logic signed [15:0] THR_GO   = 16'sd128;

   localparam logic signed [7:0] GEAR_IDLE  = -8'sd100;
   localparam logic signed [7:0] GEAR_FIRST = 8'sd0;
   localparam logic signed [7:0] GEAR_DRIVE = 8'sd100;

   localparam logic [14:0] MOTOR_MAX       = 15'd25600;
   localparam logic [19:0] RPM_LIMIT_THREE = 20'd1;

   // elapsed * accel / 1e6 >= 25600 iff product >= 25600 * 1e6
   localparam int            ELAPSED_LOW_W = 35;
   localparam int            PRODUCT_W     = ELAPSED_LOW_W + 16;
   localparam logic [PRODUCT_W-1:0] SAT_PRODUCT = 51'd25600000000;

   // 1e6 = 64 * 15625; floor(x / 15625) = (x * RECIP_M) >> RECIP_SHIFT for x < 2^29
   localparam int          DIV_PRE_SHIFT = 6;
   localparam int          DIVIDEND_W    = 29;
   localparam int          RECIP_W       = 30;
   localparam int          RECIP_SHIFT   = 43;
   localparam logic [RECIP_W-1:0] RECIP_M = 30'd562949954;

   typedef struct packed {
      logic [15:0] accel_one;
      logic [15:0] accel_two;
      logic [15:0] accel_three;
      logic [31:0] time_one;
      logic [31:0] time_two;
      logic [31:0] time_three;
      logic [19:0] rpm_one;
      logic [19:0] rpm_two;
   } cfg_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [47:0] now_us;
      logic [19:0] motor_rpm;
   } item_type;

endpackage

// ----- design/lsc_if.sv -----
// Valid/ready channel interfaces for the launch sequence controller.
// Depends on nothing; the request carries one control tick, the response one result.
interface lsc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] throttle;
   logic [47:0]        now_us;
   logic [19:0]        motor_rpm;

   modport source (output valid, output throttle, output now_us, output motor_rpm,
                   input ready);
   modport sink   (input valid, input throttle, input now_us, input motor_rpm,
                   output ready);
endinterface

interface lsc_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] gear_setpoint;
   logic [14:0]       motor_setpoint;
   logic [1:0]        phase;
   logic              launch_done;

   modport source (output valid, output gear_setpoint, output motor_setpoint,
                   output phase, output launch_done, input ready);
   modport sink   (input valid, input gear_setpoint, input motor_setpoint,
                   input phase, input launch_done, output ready);
endinterface

// ----- design/lsc_front.sv -----
// Front end: accepts tick beats, classifies throttle, holds them in a two-entry queue.
// Depends on lsc_pkg and lsc_req_if.
module lsc_front
   import lsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lsc_req_if.sink    req,
   output logic       item_valid,
   output item_type   item,
   input  logic       item_pop
);

   item_type    entries_ff [2];
   logic [1:0]  count_ff, count_in;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic        push;
   cmd_type     cmd;

   always_comb begin
      if (req.throttle < THR_STOP) begin
         cmd = CMD_STOP;
      end else if (req.throttle > THR_GO) begin
         cmd = CMD_GO;
      end else begin
         cmd = CMD_HOLD;
      end
   end

   assign req.ready  = !reset && (count_ff != 2'd2);
   assign push       = req.valid && req.ready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= '{cmd: cmd, now_us: req.now_us, motor_rpm: req.motor_rpm};
      end
   end

endmodule

// ----- design/lsc_back.sv -----
// Back end: phase sequencing, ramp multiply, reciprocal scale and saturating sum.
// Depends on lsc_pkg and lsc_rsp_if; holds the launch state and the result register.
module lsc_back
   import lsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_pop,
   lsc_rsp_if.source  rsp
);

   state_type state_ff, state_in;

   phase_type   phase_ff, phase_in;
   logic [47:0] start_ff, start_in;
   logic [14:0] level_ff, level_in;

   logic [47:0]          elapsed_ff;
   logic [15:0]          accel_ff;
   logic                 ramp_ff;
   logic signed [7:0]    gear_ff;
   phase_type            phase_out_ff;
   logic                 done_ff;
   logic                 sat_ff;
   logic [PRODUCT_W-1:0] prod_ff;
   logic [14:0]          quot_ff;

   logic              rsp_valid_ff;
   logic signed [7:0] rsp_gear_ff;
   logic [14:0]       rsp_motor_ff;
   phase_type         rsp_phase_ff;
   logic              rsp_done_ff;

   logic commit;

   // per-tick decision
   phase_type         eff_phase;
   logic [47:0]       elapsed;
   logic [15:0]       accel_sel;
   logic              ramp_sel;
   logic signed [7:0] gear_sel;
   logic              done_sel;
   logic              advance;

   logic [DIVIDEND_W+RECIP_W-1:0] scaled;
   logic [15:0]                   sum;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (item_valid) state_in = ST_MUL;
         ST_MUL:  state_in = ST_DIV;
         ST_DIV:  state_in = ST_SUM;
         ST_SUM:  if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      item_pop = 1'b0;
      commit   = 1'b0;
      case (state_ff)
         ST_IDLE: item_pop = item_valid;
         ST_SUM:  commit   = !rsp_valid_ff || rsp.ready;
         default: begin
            item_pop = 1'b0;
            commit   = 1'b0;
         end
      endcase
   end

   always_comb begin
      eff_phase = (item.cmd == CMD_STOP) ? PHASE_IDLE : phase_ff;
      elapsed   = item.now_us - start_ff;
      accel_sel = cfg.accel_one;
      ramp_sel  = 1'b1;
      gear_sel  = GEAR_IDLE;
      done_sel  = 1'b0;
      advance   = 1'b0;
      phase_in  = eff_phase;
      case (eff_phase)
         PHASE_IDLE: begin
            ramp_sel = 1'b0;
            advance  = (item.cmd == CMD_GO);
            phase_in = advance ? PHASE_ONE : PHASE_IDLE;
         end
         PHASE_ONE: begin
            gear_sel = GEAR_FIRST;
            advance  = (item.motor_rpm > cfg.rpm_one) || (elapsed > {16'd0, cfg.time_one});
            phase_in = advance ? PHASE_TWO : PHASE_ONE;
         end
         PHASE_TWO: begin
            gear_sel  = GEAR_DRIVE;
            accel_sel = cfg.accel_two;
            advance   = (item.motor_rpm > cfg.rpm_two) || (elapsed > {16'd0, cfg.time_two});
            phase_in  = advance ? PHASE_THREE : PHASE_TWO;
         end
         default: begin
            gear_sel  = GEAR_DRIVE;
            accel_sel = cfg.accel_three;
            done_sel  = (item.motor_rpm > RPM_LIMIT_THREE) ||
                        (elapsed > {16'd0, cfg.time_three});
         end
      endcase
      start_in = advance ? item.now_us : start_ff;
   end

   assign scaled = prod_ff[DIV_PRE_SHIFT +: DIVIDEND_W] * RECIP_M;
   assign sum    = {1'b0, level_ff} + {1'b0, quot_ff};

   always_comb begin
      if (!ramp_ff) begin
         level_in = 15'd0;
      end else if (sat_ff || sum >= {1'b0, MOTOR_MAX}) begin
         level_in = MOTOR_MAX;
      end else begin
         level_in = sum[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PHASE_IDLE;
         start_ff     <= 48'd0;
         level_ff     <= 15'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (item_pop) begin
            phase_ff <= phase_in;
            start_ff <= start_in;
         end
         if (commit) begin
            level_ff     <= level_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         elapsed_ff   <= elapsed;
         accel_ff     <= accel_sel;
         ramp_ff      <= ramp_sel;
         gear_ff      <= gear_sel;
         phase_out_ff <= phase_in;
         done_ff      <= done_sel;
      end
      if (state_ff == ST_MUL) begin
         sat_ff  <= (elapsed_ff[47:ELAPSED_LOW_W] != '0) && (accel_ff != 16'd0);
         prod_ff <= elapsed_ff[ELAPSED_LOW_W-1:0] * accel_ff;
      end
      if (state_ff == ST_DIV) begin
         sat_ff  <= sat_ff || (prod_ff >= SAT_PRODUCT);
         quot_ff <= scaled[RECIP_SHIFT +: 15];
      end
      if (commit) begin
         rsp_gear_ff  <= gear_ff;
         rsp_motor_ff <= level_in;
         rsp_phase_ff <= phase_out_ff;
         rsp_done_ff  <= done_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.gear_setpoint  = rsp_gear_ff;
   assign rsp.motor_setpoint = rsp_motor_ff;
   assign rsp.phase          = rsp_phase_ff;
   assign rsp.launch_done    = rsp_done_ff;

endmodule

// ----- design/launch_sequence_controller.sv -----
// Launch sequence controller top level: CSR bank, front queue and back end.
// Depends on lsc_pkg, lsc_if, lsc_front and lsc_back.
//
// One tick beat in, one result beat out. Each tick passes four steps in the back end
// (state decision, ramp multiply, reciprocal scale by 1/1e6, saturating add); the back
// end takes no new tick until the last result is registered; a two-entry queue in front
// keeps the request side flowing while a result waits at the output register. The
// setpoint ramp uses the elapsed time since the current phase began; throttle under 0.1
// returns to idle on the same tick. Registers are written through csr_we / csr_addr /
// csr_wdata and must only change while no tick is in flight.
module launch_sequence_controller
   import lsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lsc_req_if.sink               req_bus,
   lsc_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg_ff;
   logic     item_valid;
   item_type item;
   logic     item_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_one   <= 16'd256;
         cfg_ff.accel_two   <= 16'd256;
         cfg_ff.accel_three <= 16'd256;
         cfg_ff.time_one    <= 32'd1000000;
         cfg_ff.time_two    <= 32'd1000000;
         cfg_ff.time_three  <= 32'd1000000;
         cfg_ff.rpm_one     <= 20'd59;
         cfg_ff.rpm_two     <= 20'd59;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_ACCEL_ONE:   cfg_ff.accel_one   <= csr_wdata[15:0];
            CSR_ACCEL_TWO:   cfg_ff.accel_two   <= csr_wdata[15:0];
            CSR_ACCEL_THREE: cfg_ff.accel_three <= csr_wdata[15:0];
            CSR_TIME_ONE:    cfg_ff.time_one    <= csr_wdata;
            CSR_TIME_TWO:    cfg_ff.time_two    <= csr_wdata;
            CSR_TIME_THREE:  cfg_ff.time_three  <= csr_wdata;
            CSR_RPM_ONE:     cfg_ff.rpm_one     <= csr_wdata[19:0];
            CSR_RPM_TWO:     cfg_ff.rpm_two     <= csr_wdata[19:0];
            default:         cfg_ff             <= cfg_ff;
         endcase
      end
   end

   lsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   lsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp        (rsp_bus)
   );

endmodule

// ----- bench/tb_launch_sequence_controller.sv -----
`timescale 1ns / 100ps
// Self-checking bench for launch_sequence_controller: directed tick table, then
// random launch sequences over several register settings. Needs lsc_pkg, lsc_if, the top.
module tb_launch_sequence_controller;
   import lsc_pkg::*;

   localparam int N_SETTINGS     = 8;
   localparam int RAND_PER_SET   = 230;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_AT_BEAT   = 300;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic signed [15:0] THROTTLE_STOP = 16'sd26;
   localparam logic signed [15:0] THROTTLE_GO   = 16'sd128;
   localparam logic signed [7:0]  GEAR_AT_IDLE  = -8'sd100;
   localparam logic signed [7:0]  GEAR_IN_FIRST = 8'sd0;
   localparam logic signed [7:0]  GEAR_IN_DRIVE = 8'sd100;
   localparam logic [14:0]        MOTOR_FULL    = 15'd25600;

   typedef struct packed {
      logic signed [7:0] gear;
      logic [14:0]       motor;
      phase_type         phase;
      logic              done;
   } setpoint_type;

   typedef struct packed {
      logic signed [15:0] thr;
      logic [47:0]        now;
      logic [19:0]        rpm;
      logic               typed_in;
      setpoint_type       res;
   } tick_row_type;

   localparam setpoint_type IDLE_OUT  = '{GEAR_AT_IDLE, 15'd0, PHASE_IDLE, 1'b0};
   localparam setpoint_type START_OUT = '{GEAR_AT_IDLE, 15'd0, PHASE_ONE, 1'b0};
   localparam setpoint_type NO_OUT    = '0;
   localparam int TABLE_ROWS = 20;

   tick_row_type tick_table [TABLE_ROWS] = '{
      '{16'sd0,      48'd0,               20'd0,       1'b1, IDLE_OUT},
      '{16'sh8000,   48'hFFFF_FFFF_FFFF,  20'hFFFFF,   1'b1, IDLE_OUT},
      '{16'sd25,     48'd100,             20'd500,     1'b1, IDLE_OUT},
      '{16'sd128,    48'd200,             20'd0,       1'b1, IDLE_OUT},
      '{16'sd129,    48'd1000,            20'd0,       1'b1, START_OUT},
      '{16'sh7FFF,   48'd501000,          20'd0,       1'b0, NO_OUT},
      '{16'sd26,     48'd600000,          20'd60,      1'b0, NO_OUT},
      '{16'sd25600,  48'd1600001,         20'd59,      1'b0, NO_OUT},
      '{16'sd25600,  48'd1700000,         20'd1,       1'b0, NO_OUT},
      '{16'sd25600,  48'd1800000,         20'd2,       1'b0, NO_OUT},
      '{16'sd25600,  48'd2700000,         20'd0,       1'b0, NO_OUT},
      '{16'sd25600,  48'd500,             20'd0,       1'b0, NO_OUT},
      '{16'sd25,     48'd600,             20'd0,       1'b1, IDLE_OUT},
      '{16'sh7FFF,   48'hFFFF_FFFF_FF00,  20'd0,       1'b1, START_OUT},
      '{16'sd1000,   48'h0000_0000_0100,  20'd0,       1'b0, NO_OUT},
      '{16'sd1000,   48'hFFFF_FFFF_FFFF,  20'hFFFFF,   1'b0, NO_OUT},
      '{16'sd26,     48'hFFFF_FFFF_FFFF,  20'd0,       1'b0, NO_OUT},
      '{-16'sd1,     48'd0,               20'd0,       1'b1, IDLE_OUT},
      '{16'sd25600,  48'd5000,            20'd0,       1'b1, START_OUT},
      '{-16'sd25600, 48'd6000,            20'd0,       1'b1, IDLE_OUT}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lsc_req_if req_bus ();
   lsc_rsp_if rsp_bus ();

   launch_sequence_controller uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of registers and sequencer state
   logic [15:0] cfg_accel [3];
   logic [31:0] cfg_time [3];
   logic [19:0] cfg_rpm [2];
   phase_type   seq_phase;
   logic [47:0] seq_start;
   logic [14:0] seq_level;

   setpoint_type pending_setpoints [$];
   int           mismatches   = 0;
   int           result_beats = 0;
   int           quiet_cycles = 0;
   bit           no_idle      = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [14:0] ramp_level(logic [14:0] level, logic [47:0] elapsed,
                                              logic [15:0] accel);
      logic [63:0] inc;
      inc = ({16'd0, elapsed} * {48'd0, accel}) / 64'd1000000;
      if (inc >= 64'(MOTOR_FULL) || 64'(level) + inc >= 64'(MOTOR_FULL))
         return MOTOR_FULL;
      return level + inc[14:0];
   endfunction

   function automatic setpoint_type predict_setpoints(logic signed [15:0] thr,
                                                      logic [47:0] now,
                                                      logic [19:0] rpm);
      setpoint_type r;
      logic [47:0]  elapsed;
      r.gear = GEAR_AT_IDLE;
      r.done = 1'b0;
      if (thr < THROTTLE_STOP)
         seq_phase = PHASE_IDLE;
      elapsed = now - seq_start;
      case (seq_phase)
         PHASE_IDLE: begin
            seq_level = '0;
            if (thr > THROTTLE_GO) begin
               seq_phase = PHASE_ONE;
               seq_start = now;
            end
         end
         PHASE_ONE: begin
            r.gear    = GEAR_IN_FIRST;
            seq_level = ramp_level(seq_level, elapsed, cfg_accel[0]);
            if (rpm > cfg_rpm[0] || elapsed > 48'(cfg_time[0])) begin
               seq_phase = PHASE_TWO;
               seq_start = now;
            end
         end
         PHASE_TWO: begin
            r.gear    = GEAR_IN_DRIVE;
            seq_level = ramp_level(seq_level, elapsed, cfg_accel[1]);
            if (rpm > cfg_rpm[1] || elapsed > 48'(cfg_time[1])) begin
               seq_phase = PHASE_THREE;
               seq_start = now;
            end
         end
         default: begin
            r.gear    = GEAR_IN_DRIVE;
            seq_level = ramp_level(seq_level, elapsed, cfg_accel[2]);
            if (rpm > RPM_LIMIT_THREE || elapsed > 48'(cfg_time[2]))
               r.done = 1'b1;
         end
      endcase
      r.motor = seq_level;
      r.phase = seq_phase;
      return r;
   endfunction

   function automatic logic [31:0] reg_value(int setting, logic [31:0] typical);
      if (setting == 1)
         return '0;
      if (setting == 2)
         return '1;
      if ($urandom_range(0, 5) == 0)
         return $urandom;
      return typical;
   endfunction

   task automatic csr_write(csr_index_type idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_ACCEL_ONE:   cfg_accel[0] = data[15:0];
         CSR_ACCEL_TWO:   cfg_accel[1] = data[15:0];
         CSR_ACCEL_THREE: cfg_accel[2] = data[15:0];
         CSR_TIME_ONE:    cfg_time[0]  = data;
         CSR_TIME_TWO:    cfg_time[1]  = data;
         CSR_TIME_THREE:  cfg_time[2]  = data;
         CSR_RPM_ONE:     cfg_rpm[0]   = data[19:0];
         CSR_RPM_TWO:     cfg_rpm[1]   = data[19:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // offer one tick beat; on acceptance queue its expected result
   task automatic send_tick(logic signed [15:0] thr, logic [47:0] now, logic [19:0] rpm,
                            logic typed_in, setpoint_type typed_res);
      int           gap;
      setpoint_type want;
      gap = no_idle ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.throttle  <= thr;
      req_bus.now_us    <= now;
      req_bus.motor_rpm <= rpm;
      do @(posedge clock); while (!req_bus.ready);
      want = predict_setpoints(thr, now, rpm);
      if (typed_in)
         want = typed_res;
      pending_setpoints.push_back(want);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic drain_and_settle();
      while (pending_setpoints.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("launch_sequence_controller regression: fail");
      $finish;
   end

   initial begin : result_sink
      int           stall;
      setpoint_type want;
      do @(posedge clock); while (reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 16);
         if (result_beats == HOLD_AT_BEAT)
            stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         result_beats++;
         if (pending_setpoints.size() == 0) begin
            $display("%0t: result beat with none expected, expected none actual gear %0d",
                     $time, rsp_bus.gear_setpoint);
            mismatches++;
         end else begin
            want = pending_setpoints.pop_front();
            check_field("gear_setpoint", want.gear, rsp_bus.gear_setpoint);
            check_field("motor_setpoint", want.motor, rsp_bus.motor_setpoint);
            check_field("phase", want.phase, rsp_bus.phase);
            check_field("launch_done", want.done, rsp_bus.launch_done);
         end
      end
   end

   initial begin : stimulus
      int                 pick;
      int                 t;
      logic signed [15:0] thr;
      logic [47:0]        clock_us;
      logic [19:0]        rpm;

      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_addr          <= '0;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.throttle  <= '0;
      req_bus.now_us    <= '0;
      req_bus.motor_rpm <= '0;
      rsp_bus.ready     <= 1'b0;

      cfg_accel = '{16'd256, 16'd256, 16'd256};
      cfg_time  = '{32'd1000000, 32'd1000000, 32'd1000000};
      cfg_rpm   = '{20'd59, 20'd59};
      seq_phase = PHASE_IDLE;
      seq_start = '0;
      seq_level = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int s = 0; s < N_SETTINGS; s++) begin
         if (s > 0) begin
            drain_and_settle();
            csr_write(CSR_ACCEL_ONE,   reg_value(s, $urandom_range(0, 20000)));
            csr_write(CSR_ACCEL_TWO,   reg_value(s, $urandom_range(0, 20000)));
            csr_write(CSR_ACCEL_THREE, reg_value(s, $urandom_range(0, 20000)));
            csr_write(CSR_TIME_ONE,    reg_value(s, $urandom_range(0, 3000000)));
            csr_write(CSR_TIME_TWO,    reg_value(s, $urandom_range(0, 3000000)));
            csr_write(CSR_TIME_THREE,  reg_value(s, $urandom_range(0, 3000000)));
            csr_write(CSR_RPM_ONE,     reg_value(s, $urandom_range(0, 2000)));
            csr_write(CSR_RPM_TWO,     reg_value(s, $urandom_range(0, 2000)));
            csr_we <= 1'b0;
         end
         no_idle = (s == 3) || ($urandom_range(0, 3) == 0);

         if (s == 0)
            for (int i = 0; i < TABLE_ROWS; i++)
               send_tick(tick_table[i].thr, tick_table[i].now, tick_table[i].rpm,
                         tick_table[i].typed_in, tick_table[i].res);

         clock_us = 48'({$urandom, $urandom});
         for (int n = 0; n < RAND_PER_SET; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               send_tick(16'($urandom), 48'({$urandom, $urandom}), 20'($urandom), 1'b0, '0);
            end else begin
               if (pick < 14)
                  thr = $urandom_range(0, 1) ? 16'($urandom_range(0, 25))
                                             : 16'(0 - int'($urandom_range(1, 32768)));
               else if (pick < 22)
                  thr = 16'($urandom_range(129, 25600));
               else
                  thr = 16'($urandom_range(26, 25600));

               t = $urandom_range(0, 99);
               if (t < 60)
                  clock_us = clock_us + $urandom_range(0, 300000);
               else if (t < 85)
                  clock_us = clock_us + $urandom_range(0, 4000000);
               else if (t < 95)
                  clock_us = clock_us + 48'($urandom);
               else
                  clock_us = clock_us - $urandom_range(0, 2000000);

               t = $urandom_range(0, 99);
               if (t < 55)
                  rpm = 20'($urandom_range(0, 40));
               else if (t < 75)
                  case ($urandom_range(0, 3))
                     0:       rpm = cfg_rpm[0];
                     1:       rpm = cfg_rpm[0] + 20'd1;
                     2:       rpm = cfg_rpm[1];
                     default: rpm = cfg_rpm[1] + 20'd1;
                  endcase
               else if (t < 95)
                  rpm = 20'($urandom_range(0, 3000));
               else
                  rpm = 20'($urandom);

               send_tick(thr, clock_us, rpm, 1'b0, '0);
            end
         end
         req_bus.valid <= 1'b0;
      end

      drain_and_settle();
      if (mismatches == 0 && pending_setpoints.size() == 0) begin
         $display("launch_sequence_controller regression: pass");
      end else begin
         $display("launch_sequence_controller regression: fail");
      end
      $finish;
   end

endmodule
